[design/slfc_pkg.sv]
// ----------------------------------------------------------------------------
// slfc_pkg
// Types, register offsets and bit positions of the serial loopback controller.
// ----------------------------------------------------------------------------
package slfc_pkg;

    typedef struct packed {
        logic        action;
        logic [11:0] address;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic [1:0]  dma_tx_pulses;
        logic [1:0]  dma_rx_pulses;
    } t_rsp;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic HAS_DMA = 1'b1;

    localparam logic [11:0] ADDR_VERID = 12'h000;
    localparam logic [11:0] ADDR_PARAM = 12'h004;
    localparam logic [11:0] ADDR_CR    = 12'h010;
    localparam logic [11:0] ADDR_SR    = 12'h014;
    localparam logic [11:0] ADDR_IER   = 12'h018;
    localparam logic [11:0] ADDR_DER   = 12'h01C;
    localparam logic [11:0] ADDR_CFGR0 = 12'h020;
    localparam logic [11:0] ADDR_CFGR1 = 12'h024;
    localparam logic [11:0] ADDR_DMR0  = 12'h030;
    localparam logic [11:0] ADDR_DMR1  = 12'h034;
    localparam logic [11:0] ADDR_CCR   = 12'h040;
    localparam logic [11:0] ADDR_CCR1  = 12'h044;
    localparam logic [11:0] ADDR_FCR   = 12'h058;
    localparam logic [11:0] ADDR_FSR   = 12'h05C;
    localparam logic [11:0] ADDR_TCR   = 12'h060;
    localparam logic [11:0] ADDR_TDR   = 12'h064;
    localparam logic [11:0] ADDR_RSR   = 12'h070;
    localparam logic [11:0] ADDR_RDR   = 12'h074;
    localparam logic [11:0] ADDR_RDROR = 12'h078;

    localparam logic [31:0] VERID_VALUE = 32'h0200_0004;
    localparam logic [31:0] PARAM_VALUE = 32'h0004_0202;
    localparam logic [31:0] TCR_RESET   = 32'h0000_001F;
    localparam logic [31:0] RSR_RXEMPTY = 32'h0000_0002;

    localparam int PLAIN_REGS = 6;

    localparam int CR_MEN = 0;
    localparam int CR_RST = 1;
    localparam int CR_RTF = 8;
    localparam int CR_RRF = 9;

    localparam int SR_TDF = 0;
    localparam int SR_RDF = 1;
    localparam int SR_WCF = 8;
    localparam int SR_FCF = 9;
    localparam int SR_TCF = 10;

    localparam int DER_TDDE = 0;
    localparam int DER_RDDE = 1;

    function automatic logic [2:0] plain_index(input logic [11:0] addr);
        logic [2:0] idx;
        unique case (addr)
            ADDR_CFGR0: idx = 3'd0;
            ADDR_CFGR1: idx = 3'd1;
            ADDR_DMR0:  idx = 3'd2;
            ADDR_DMR1:  idx = 3'd3;
            ADDR_CCR:   idx = 3'd4;
            ADDR_CCR1:  idx = 3'd5;
            default:    idx = 3'd0;
        endcase
        return idx;
    endfunction

endpackage

[design/slfc_stream_if.sv]
// ----------------------------------------------------------------------------
// slfc_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface slfc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/spi_loopback_fifo_controller.sv]
// ----------------------------------------------------------------------------
// spi_loopback_fifo_controller
// Register file of a serial controller held in internal loopback. Every
// transfer on i_req is one 32-bit register read or write, and it produces one
// transfer on o_rsp with the read data, the interrupt level and the DMA request
// counts. The block takes one access per clock cycle while o_rsp is not stalled;
// an access is captured in an input register and its result in an output
// register. All register, status and FIFO pointer updates of an access happen
// in the cycle it moves from the input to the output register. Writing the
// transmit data register with the module enabled and neither FIFO full moves
// the oldest queued transmit word, or else the written word, into the RX FIFO.
// ----------------------------------------------------------------------------
module spi_loopback_fifo_controller
    import slfc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slfc_stream_if.sink   i_req,
    slfc_stream_if.source o_rsp
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_req              r_req;
    logic              r_req_vld;
    t_rsp              r_rsp;
    logic              r_rsp_vld;

    logic [31:0]       r_cr, n_cr;
    logic [31:0]       r_ier, n_ier;
    logic [31:0]       r_der, n_der;
    logic [31:0]       r_fcr, n_fcr;
    logic [31:0]       r_tcr, n_tcr;
    logic [31:0]       r_plain [PLAIN_REGS];
    logic              r_tdf, n_tdf;
    logic              r_rdf, n_rdf;
    logic              r_wcf, n_wcf;
    logic              r_fcf, n_fcf;
    logic              r_tcf, n_tcf;
    logic              r_prev_tdf, n_prev_tdf;
    logic              r_prev_rdf, n_prev_rdf;
    logic              r_irq, n_irq;

    logic [31:0]       r_tx_mem [FIFO_DEPTH];
    logic [31:0]       r_rx_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [PTR_W-1:0]  r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [LVL_W-1:0]  r_tx_lvl, n_tx_lvl, r_rx_lvl, n_rx_lvl;

    logic              s_go;
    logic              in_acc;
    logic              tx_push, tx_pop, tx_clr;
    logic              rx_push, rx_pop, rx_clr;
    logic              plain_wr;
    logic              do_ref, do_kick, do_drive, rd_sr;
    logic              ref_tdf, ref_rdf;
    logic              tx_empty, tx_full, rx_empty, rx_full;
    logic [31:0]       move_word;
    logic [31:0]       rd_base, rd_data;
    logic [1:0]        tx_pulses, rx_pulses;
    logic [PTR_W-1:0]  tx_head_inc, tx_tail_inc, rx_head_inc, rx_tail_inc;
    logic [2:0]        plain_idx;

    assign s_go        = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld || s_go;
    assign in_acc      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_rsp_vld;
    assign o_rsp.payload = r_rsp;

    assign tx_empty = (r_tx_lvl == '0);
    assign rx_empty = (r_rx_lvl == '0);
    assign tx_full  = (r_tx_lvl == LVL_W'(FIFO_DEPTH));
    assign rx_full  = (r_rx_lvl == LVL_W'(FIFO_DEPTH));

    assign tx_head_inc = (r_tx_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_tx_tail + 1'b1;
    assign rx_head_inc = (r_rx_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
    assign rx_tail_inc = (r_rx_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rx_tail + 1'b1;

    assign move_word = tx_empty ? r_req.write_data : r_tx_mem[r_tx_head];
    assign plain_idx = plain_index(r_req.address);

    always_comb begin
        n_cr     = r_cr;
        n_ier    = r_ier;
        n_der    = r_der;
        n_fcr    = r_fcr;
        n_tcr    = r_tcr;
        n_wcf    = r_wcf;
        n_fcf    = r_fcf;
        n_tcf    = r_tcf;
        tx_push  = 1'b0;
        tx_pop   = 1'b0;
        tx_clr   = 1'b0;
        rx_push  = 1'b0;
        rx_pop   = 1'b0;
        rx_clr   = 1'b0;
        plain_wr = 1'b0;
        do_ref   = 1'b0;
        do_kick  = 1'b0;
        do_drive = 1'b0;
        rd_sr    = 1'b0;
        rd_base  = '0;
        if (s_go) begin
            unique case (r_req.address) inside
                ADDR_CFGR0, ADDR_CFGR1, ADDR_DMR0, ADDR_DMR1, ADDR_CCR, ADDR_CCR1: begin
                    if (r_req.action == ACT_WRITE) begin
                        plain_wr = 1'b1;
                    end else begin
                        rd_base = r_plain[plain_idx];
                    end
                end
                ADDR_VERID: begin
                    if (r_req.action == ACT_READ) begin
                        rd_base = VERID_VALUE;
                    end
                end
                ADDR_PARAM: begin
                    if (r_req.action == ACT_READ) begin
                        rd_base = PARAM_VALUE;
                    end
                end
                ADDR_CR: begin
                    if (r_req.action == ACT_WRITE) begin
                        n_cr     = r_req.write_data;
                        tx_clr   = r_req.write_data[CR_RST] || r_req.write_data[CR_RTF];
                        rx_clr   = r_req.write_data[CR_RST] || r_req.write_data[CR_RRF];
                        if (r_req.write_data[CR_RST]) begin
                            n_wcf = 1'b0;
                            n_fcf = 1'b0;
                            n_tcf = 1'b0;
                        end
                        do_ref   = 1'b1;
                        do_drive = 1'b1;
                    end else begin
                        rd_base = r_cr;
                    end
                end
                ADDR_SR: begin
                    if (r_req.action == ACT_WRITE) begin
                        n_wcf    = r_wcf && !r_req.write_data[SR_WCF];
                        n_fcf    = r_fcf && !r_req.write_data[SR_FCF];
                        n_tcf    = r_tcf && !r_req.write_data[SR_TCF];
                        do_drive = 1'b1;
                    end else begin
                        do_ref = 1'b1;
                        rd_sr  = 1'b1;
                    end
                end
                ADDR_IER: begin
                    if (r_req.action == ACT_WRITE) begin
                        n_ier    = r_req.write_data;
                        do_drive = 1'b1;
                    end else begin
                        rd_base = r_ier;
                    end
                end
                ADDR_DER: begin
                    if (r_req.action == ACT_WRITE) begin
                        n_der   = r_req.write_data;
                        do_ref  = 1'b1;
                        do_kick = 1'b1;
                    end else begin
                        rd_base = r_der;
                    end
                end
                ADDR_FCR: begin
                    if (r_req.action == ACT_WRITE) begin
                        n_fcr    = r_req.write_data;
                        do_ref   = 1'b1;
                        do_drive = 1'b1;
                    end else begin
                        rd_base = r_fcr;
                    end
                end
                ADDR_FSR: begin
                    if (r_req.action == ACT_READ) begin
                        do_ref  = 1'b1;
                        rd_base = {16'(r_rx_lvl), 16'(r_tx_lvl)};
                    end
                end
                ADDR_TCR: begin
                    if (r_req.action == ACT_WRITE) begin
                        n_tcr = r_req.write_data;
                    end else begin
                        rd_base = r_tcr;
                    end
                end
                ADDR_TDR: begin
                    if (r_req.action == ACT_WRITE && !tx_full) begin
                        tx_push = 1'b1;
                        if (r_cr[CR_MEN]) begin
                            if (!rx_full) begin
                                tx_pop  = 1'b1;
                                rx_push = 1'b1;
                                n_wcf   = 1'b1;
                                n_fcf   = 1'b1;
                                if (tx_empty) begin
                                    n_tcf = 1'b1;
                                end
                            end
                            do_ref   = 1'b1;
                            do_kick  = 1'b1;
                            do_drive = 1'b1;
                        end
                    end
                end
                ADDR_RSR: begin
                    if (r_req.action == ACT_READ && rx_empty) begin
                        rd_base = RSR_RXEMPTY;
                    end
                end
                ADDR_RDR: begin
                    if (r_req.action == ACT_READ && !rx_empty) begin
                        rd_base  = r_rx_mem[r_rx_head];
                        rx_pop   = 1'b1;
                        do_ref   = 1'b1;
                        do_drive = 1'b1;
                    end
                end
                ADDR_RDROR: begin
                    if (r_req.action == ACT_READ && !rx_empty) begin
                        rd_base = r_rx_mem[r_rx_head];
                    end
                end
                default: begin
                    rd_base = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_tx_lvl  = tx_clr ? '0 : r_tx_lvl + LVL_W'(tx_push) - LVL_W'(tx_pop);
        n_rx_lvl  = rx_clr ? '0 : r_rx_lvl + LVL_W'(rx_push) - LVL_W'(rx_pop);
        n_tx_head = tx_clr ? '0 : (tx_pop ? tx_head_inc : r_tx_head);
        n_tx_tail = tx_clr ? '0 : (tx_push ? tx_tail_inc : r_tx_tail);
        n_rx_head = rx_clr ? '0 : (rx_pop ? rx_head_inc : r_rx_head);
        n_rx_tail = rx_clr ? '0 : (rx_push ? rx_tail_inc : r_rx_tail);

        ref_tdf = (32'(n_tx_lvl) <= 32'(n_fcr[1:0]));
        ref_rdf = (32'(n_rx_lvl) > 32'(n_fcr[17:16]));

        n_tdf      = do_ref ? ref_tdf : r_tdf;
        n_rdf      = do_ref ? ref_rdf : r_rdf;
        n_prev_tdf = do_ref ? ref_tdf : r_prev_tdf;
        n_prev_rdf = do_ref ? ref_rdf : r_prev_rdf;

        tx_pulses = 2'(HAS_DMA && do_ref && ref_tdf && !r_prev_tdf && n_der[DER_TDDE])
                  + 2'(HAS_DMA && do_kick && n_tdf && n_der[DER_TDDE]);
        rx_pulses = 2'(HAS_DMA && do_ref && ref_rdf && !r_prev_rdf && n_der[DER_RDDE])
                  + 2'(HAS_DMA && do_kick && n_rdf && n_der[DER_RDDE]);

        n_irq = do_drive ? ((n_tdf && n_ier[SR_TDF]) || (n_rdf && n_ier[SR_RDF])
                         || (n_wcf && n_ier[SR_WCF]) || (n_fcf && n_ier[SR_FCF])
                         || (n_tcf && n_ier[SR_TCF]))
                         : r_irq;

        rd_data = rd_sr ? {21'b0, n_tcf, n_fcf, n_wcf, 6'b0, n_rdf, n_tdf} : rd_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld  <= 1'b0;
            r_rsp_vld  <= 1'b0;
            r_cr       <= '0;
            r_ier      <= '0;
            r_der      <= '0;
            r_fcr      <= '0;
            r_tcr      <= TCR_RESET;
            for (int i = 0; i < PLAIN_REGS; i++) begin
                r_plain[i] <= '0;
            end
            r_tdf      <= 1'b1;
            r_rdf      <= 1'b0;
            r_wcf      <= 1'b0;
            r_fcf      <= 1'b0;
            r_tcf      <= 1'b0;
            r_prev_tdf <= 1'b1;
            r_prev_rdf <= 1'b0;
            r_irq      <= 1'b0;
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_rx_head  <= '0;
            r_rx_tail  <= '0;
            r_tx_lvl   <= '0;
            r_rx_lvl   <= '0;
        end else begin
            r_req_vld  <= in_acc || (r_req_vld && !s_go);
            r_rsp_vld  <= s_go || (r_rsp_vld && !o_rsp.ready);
            r_cr       <= n_cr;
            r_ier      <= n_ier;
            r_der      <= n_der;
            r_fcr      <= n_fcr;
            r_tcr      <= n_tcr;
            if (plain_wr) begin
                r_plain[plain_idx] <= r_req.write_data;
            end
            r_tdf      <= n_tdf;
            r_rdf      <= n_rdf;
            r_wcf      <= n_wcf;
            r_fcf      <= n_fcf;
            r_tcf      <= n_tcf;
            r_prev_tdf <= n_prev_tdf;
            r_prev_rdf <= n_prev_rdf;
            r_irq      <= n_irq;
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_rx_head  <= n_rx_head;
            r_rx_tail  <= n_rx_tail;
            r_tx_lvl   <= n_tx_lvl;
            r_rx_lvl   <= n_rx_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_req.payload;
        end
        if (s_go) begin
            r_rsp.read_data     <= rd_data;
            r_rsp.irq           <= n_irq;
            r_rsp.dma_tx_pulses <= tx_pulses;
            r_rsp.dma_rx_pulses <= rx_pulses;
        end
        if (tx_push) begin
            r_tx_mem[r_tx_tail] <= r_req.write_data;
        end
        if (rx_push) begin
            r_rx_mem[r_rx_tail] <= move_word;
        end
    end

    a_levels_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_tx_lvl) <= FIFO_DEPTH) && (32'(r_rx_lvl) <= FIFO_DEPTH))
        else $error("FIFO level above depth");

    a_tx_pulse_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && tx_pulses != 2'd0) |=> r_der[DER_TDDE])
        else $error("transmit DMA request without enable");

    a_tcf_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && !r_tcf && n_tcf) |=> (r_tx_lvl == '0))
        else $error("transfer complete set with words left in TX FIFO");

    a_access_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && !r_rsp_vld) |=> r_rsp_vld)
        else $error("captured access did not reach the result register");

endmodule
